### rtl/cfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, codes and defaults for the clock frame replacement block.
// ----------------------------------------------------------------------------
package cfr_pkg;

   // default pool size
   localparam int FRAMES_DEFAULT = 64;

   // request function codes
   localparam int FUNC_W = 2;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PIN     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DIRTY   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd3;

   // operation codes for the shared entry unit
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_SCAN    = 3'd0;
   localparam logic [OP_W-1:0] OP_SWEEP   = 3'd1;
   localparam logic [OP_W-1:0] OP_PIN     = 3'd2;
   localparam logic [OP_W-1:0] OP_DIRTY   = 3'd3;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

   // marks of one frame, as held in the mark memory
   typedef struct packed {
      logic valid;
      logic pin;
      logic refd;
      logic dirty;
   } marks_type;

   localparam int MARKS_W = $bits(marks_type);

   // decision of the entry unit for one frame
   typedef struct packed {
      logic      wr_en;
      marks_type wr_data;
      logic      finish;
      logic      found;
      logic      set_hand;
      logic      write_back;
      logic      inc_use;
      logic      dec_use;
      logic      pin_inc;
      logic      pin_dec;
   } eval_type;

endpackage

### rtl/cfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module cfr_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cfr_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_eval
// Shared entry unit: judges one frame's marks for the current operation and
// gives the updated marks plus the bookkeeping decisions.
// ----------------------------------------------------------------------------
module cfr_eval (
   input  logic [cfr_pkg::OP_W-1:0] op,
   input  cfr_pkg::marks_type       marks,
   input  logic                     flag,
   output cfr_pkg::eval_type        decision
);

   cfr_pkg::marks_type loaded;

   // marks of a freshly loaded frame
   always_comb begin
      loaded.valid = 1'b1;
      loaded.pin   = flag;
      loaded.refd  = ~flag;
      loaded.dirty = 1'b0;
   end

   always_comb begin
      decision = '0;
      decision.wr_data = marks;
      unique case (op)
         cfr_pkg::OP_SCAN: begin
            // first free frame wins, a free frame may already carry a pin
            if (!marks.valid) begin
               decision.wr_en   = 1'b1;
               decision.wr_data = loaded;
               decision.finish  = 1'b1;
               decision.found   = 1'b1;
               decision.inc_use = 1'b1;
               decision.pin_inc = flag & ~marks.pin;
               decision.pin_dec = ~flag & marks.pin;
            end
         end
         cfr_pkg::OP_SWEEP: begin
            // skip pinned, second chance for referenced
            if (!marks.pin) begin
               if (marks.refd) begin
                  decision.wr_en        = 1'b1;
                  decision.wr_data.refd = 1'b0;
               end else begin
                  decision.wr_en      = 1'b1;
                  decision.wr_data    = loaded;
                  decision.finish     = 1'b1;
                  decision.found      = 1'b1;
                  decision.set_hand   = 1'b1;
                  decision.write_back = marks.dirty;
                  decision.pin_inc    = flag;
               end
            end
         end
         cfr_pkg::OP_PIN: begin
            decision.wr_en        = 1'b1;
            decision.wr_data.pin  = flag;
            decision.wr_data.refd = flag ? marks.refd : 1'b1;
            decision.finish       = 1'b1;
            decision.pin_inc      = flag & ~marks.pin;
            decision.pin_dec      = ~flag & marks.pin;
         end
         cfr_pkg::OP_DIRTY: begin
            decision.wr_en         = 1'b1;
            decision.wr_data.dirty = flag;
            decision.finish        = 1'b1;
         end
         cfr_pkg::OP_RELEASE: begin
            decision.finish = 1'b1;
            if (marks.valid) begin
               decision.wr_en   = 1'b1;
               decision.wr_data = '0;
               decision.dec_use = 1'b1;
               decision.pin_dec = marks.pin;
            end
         end
         default: begin
            decision.finish = 1'b1;
         end
      endcase
   end

endmodule

### rtl/clock_frame_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_frame_replacement
// Clock (second-chance) frame replacement for a pool of buffer frames.
// ----------------------------------------------------------------------------
// Takes one request word at a time and returns one response word for it. The
// frame marks live in a single-port-write RAM that one shared entry unit
// visits one frame at a time (address, then judge and write back). After
// reset a clearing pass zeroes every frame before the first request is
// taken. Set pin, set dirty and release visit only the target frame;
// allocate into a pool that is not full scans up from frame 0 to the lowest
// free frame; allocate into a full pool sweeps on from the frame after the
// hand; allocate into a full pool with every frame pinned answers no-frame
// without visiting any frame. A response held off by the receiver holds the
// sequencer in its done state until the output register is free. A new
// request is taken only when the sequencer is idle.
// ----------------------------------------------------------------------------
module clock_frame_replacement #(
   parameter int FRAMES = cfr_pkg::FRAMES_DEFAULT,
   localparam int IdxW = $clog2(FRAMES)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [cfr_pkg::FUNC_W-1:0] req_func,
   input  logic [IdxW-1:0]            req_frame_index,
   input  logic                       req_flag_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [IdxW-1:0]            rsp_chosen_frame,
   output logic                       rsp_status,
   output logic                       rsp_write_back
);

   localparam int CntW = $clog2(FRAMES + 1);
   localparam logic [IdxW-1:0] LastIdx   = IdxW'(FRAMES - 1);
   localparam logic [IdxW:0]   FramesIdx = (IdxW + 1)'(FRAMES);
   localparam logic [CntW-1:0] FramesCnt = CntW'(FRAMES);

   // sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_LOOKUP = 3'd2;
   localparam logic [2:0] ST_EVAL   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [IdxW-1:0]           pos_ff, pos_in;
   logic [cfr_pkg::OP_W-1:0]  op_ff, op_in;
   logic                      flag_ff, flag_in;
   logic [IdxW-1:0]           hand_ff, hand_in;
   logic [CntW-1:0]           in_use_ff, in_use_in;
   logic [CntW-1:0]           pinned_ff, pinned_in;
   logic [IdxW-1:0]           res_frame_ff, res_frame_in;
   logic                      res_status_ff, res_status_in;
   logic                      res_wb_ff, res_wb_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IdxW-1:0]           rsp_frame_ff, rsp_frame_in;
   logic                      rsp_status_ff, rsp_status_in;
   logic                      rsp_wb_ff, rsp_wb_in;

   logic                      ram_we;
   cfr_pkg::marks_type        ram_wdata;
   logic [cfr_pkg::MARKS_W-1:0] ram_rdata;
   cfr_pkg::marks_type        marks;
   cfr_pkg::eval_type         decision;
   logic [IdxW-1:0]           pos_next;
   logic [IdxW-1:0]           hand_next;
   logic                      req_fire;
   logic                      idx_in_range;
   logic                      rsp_free;

   // mark memory
   cfr_ram #(
      .WIDTH (cfr_pkg::MARKS_W),
      .DEPTH (FRAMES)
   ) u_marks (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff),
      .wr_data (ram_wdata),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   assign marks = cfr_pkg::marks_type'(ram_rdata);

   // shared entry unit
   cfr_eval u_eval (
      .op       (op_ff),
      .marks    (marks),
      .flag     (flag_ff),
      .decision (decision)
   );

   // wrap-around stepping
   assign pos_next  = (pos_ff == LastIdx) ? '0 : pos_ff + 1'b1;
   assign hand_next = (hand_ff == LastIdx) ? '0 : hand_ff + 1'b1;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid & req_ready;
   assign idx_in_range = ({1'b0, req_frame_index} < FramesIdx);
   assign rsp_free     = ~rsp_valid_ff | rsp_ready;

   // memory write: zero during clearing, unit decision while judging
   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = decision.wr_data;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_wdata = '0;
      end else if (state_ff == ST_EVAL) begin
         ram_we = decision.wr_en;
      end
   end

   // sequencer and bookkeeping
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      op_in         = op_ff;
      flag_in       = flag_ff;
      hand_in       = hand_ff;
      in_use_in     = in_use_ff;
      pinned_in     = pinned_ff;
      res_frame_in  = res_frame_ff;
      res_status_in = res_status_ff;
      res_wb_in     = res_wb_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_frame_in  = rsp_frame_ff;
      rsp_status_in = rsp_status_ff;
      rsp_wb_in     = rsp_wb_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            pos_in = pos_next;
            if (pos_ff == LastIdx) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               flag_in       = req_flag_value;
               res_status_in = 1'b0;
               res_wb_in     = 1'b0;
               res_frame_in  = req_frame_index;
               state_in      = ST_LOOKUP;
               pos_in        = req_frame_index;
               unique case (req_func)
                  cfr_pkg::FUNC_ALLOC: begin
                     res_frame_in = '0;
                     if (in_use_ff != FramesCnt) begin
                        op_in  = cfr_pkg::OP_SCAN;
                        pos_in = '0;
                     end else if (pinned_ff == FramesCnt) begin
                        res_status_in = 1'b1;
                        state_in      = ST_DONE;
                     end else begin
                        op_in  = cfr_pkg::OP_SWEEP;
                        pos_in = hand_next;
                     end
                  end
                  cfr_pkg::FUNC_PIN:     op_in = cfr_pkg::OP_PIN;
                  cfr_pkg::FUNC_DIRTY:   op_in = cfr_pkg::OP_DIRTY;
                  cfr_pkg::FUNC_RELEASE: op_in = cfr_pkg::OP_RELEASE;
                  default:               op_in = cfr_pkg::OP_RELEASE;
               endcase
               // out-of-range targets only echo
               if (req_func != cfr_pkg::FUNC_ALLOC && !idx_in_range) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LOOKUP: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // apply the unit's decision
            in_use_in = in_use_ff + CntW'(decision.inc_use)
                        - CntW'(decision.dec_use && in_use_ff != '0);
            pinned_in = pinned_ff + CntW'(decision.pin_inc) - CntW'(decision.pin_dec);
            if (decision.found) begin
               res_frame_in = pos_ff;
            end
            if (decision.set_hand) begin
               hand_in = pos_ff;
            end
            res_wb_in = decision.write_back;
            if (decision.finish) begin
               state_in = ST_DONE;
            end else if (op_ff == cfr_pkg::OP_SCAN && pos_ff == LastIdx) begin
               res_status_in = 1'b1;
               state_in      = ST_DONE;
            end else begin
               pos_in   = pos_next;
               state_in = ST_LOOKUP;
            end
         end
         ST_DONE: begin
            // hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_frame_in  = res_frame_ff;
               rsp_status_in = res_status_ff;
               rsp_wb_in     = res_wb_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         hand_ff      <= '0;
         in_use_ff    <= '0;
         pinned_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= cfr_pkg::OP_SCAN;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         hand_ff      <= hand_in;
         in_use_ff    <= in_use_in;
         pinned_ff    <= pinned_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      flag_ff       <= flag_in;
      res_frame_ff  <= res_frame_in;
      res_status_ff <= res_status_in;
      res_wb_ff     <= res_wb_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wb_ff     <= rsp_wb_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_frame = rsp_frame_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_write_back   = rsp_wb_ff;

   // frames in use never exceed the pool
   a_in_use_bound: assert property (@(posedge clock) disable iff (reset)
      in_use_ff <= FramesCnt)
      else $error("frames in use beyond pool size");

   // pinned count never exceeds the pool
   a_pinned_bound: assert property (@(posedge clock) disable iff (reset)
      pinned_ff <= FramesCnt)
      else $error("pinned count beyond pool size");

   // a no-frame answer never asks for write-back
   a_nofr_no_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_status_ff && rsp_wb_ff))
      else $error("no-frame response with write-back");

   // the mark memory is left alone while idle
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("mark memory written while idle");

endmodule
